>>> design/binary_min_heap_priority_queue_macros.svh
// Assertion macros shared by the priority queue modules.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define BMHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define BMHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bmhpq_pkg.sv
// Package for the min priority queue: sizes, opcodes, status codes and beat types.
// No dependencies.
`timescale 1ns / 1ps

package bmhpq_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int OCC_W     = 7;
    localparam int FIELD_W   = 32;

    // Opcodes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One key slot, also used for the carry moving down the chain
    typedef struct packed {
        logic                 vld;
        logic [KEY_WIDTH-1:0] key;
    } t_slot;

    // Command beat
    typedef struct packed {
        logic               opcode;
        logic [FIELD_W-1:0] key_value;
    } t_cmd;

    // Response beat
    typedef struct packed {
        logic [FIELD_W-1:0] popped_key;
        logic [FIELD_W-1:0] min_key;
        logic [OCC_W-1:0]   occupancy;
        logic               heap_empty;
        t_status            status;
    } t_rsp;

endpackage

>>> design/binary_min_heap_priority_queue.sv
// Min priority queue over a chain of CAPACITY key cells kept in ascending order.
// Result strobe comes in the cycle after start is taken. Pops and dropped pushes leave
// busy low; a push into a non-empty queue keeps busy high while the displaced key ripples
// one cell per cycle down the chain. Synchronous active-low reset empties the queue.
// Depends on bmhpq_pkg, bmhpq_cell and the assertion macro header.
`timescale 1ns / 1ps
`include "binary_min_heap_priority_queue_macros.svh"

module binary_min_heap_priority_queue import bmhpq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_rsp_vld,
    output t_rsp o_rsp
);

    t_slot w_slot  [CAPACITY+1];
    t_slot w_carry [CAPACITY+1];
    logic [CAPACITY-1:0] w_vld;
    logic [CAPACITY-1:0] w_cvld;

    logic             w_accept;
    logic             w_pop;
    t_slot            w_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_rsp_vld;
    t_rsp             r_rsp, n_rsp;
    logic [KEY_WIDTH-1:0] w_key;

    // Chain of cells; the tail sees an empty neighbor
    assign w_slot[CAPACITY] = '0;
    assign w_carry[0]       = w_head;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        bmhpq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pop   (w_pop),
            .i_carry (w_carry[g]),
            .i_next  (w_slot[g+1]),
            .o_slot  (w_slot[g]),
            .o_carry (w_carry[g+1])
        );
        assign w_vld[g]  = w_slot[g].vld;
        assign w_cvld[g] = w_carry[g+1].vld;
    end

    // Busy while any displaced key is still moving
    assign busy     = |w_cvld;
    assign w_accept = start && !busy;
    assign w_key    = KEY_WIDTH'(i_cmd.key_value);

    // Command decode and response build
    always_comb begin
        n_count       = r_count;
        w_pop         = 1'b0;
        w_head        = '{vld: 1'b0, key: w_key};
        n_rsp.popped_key = '0;
        n_rsp.min_key    = w_slot[0].vld ? FIELD_W'(w_slot[0].key) : '0;
        n_rsp.status     = ST_OK;
        if (w_accept) begin
            if (i_cmd.opcode == OP_PUSH) begin
                if (r_count == CNT_W'(CAPACITY)) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    n_count    = r_count + 1'b1;
                    w_head.vld = 1'b1;
                    if (!w_slot[0].vld || w_key < w_slot[0].key) begin
                        n_rsp.min_key = FIELD_W'(w_key);
                    end
                end
            end else begin
                if (r_count == '0) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    n_count          = r_count - 1'b1;
                    w_pop            = 1'b1;
                    n_rsp.popped_key = FIELD_W'(w_slot[0].key);
                    n_rsp.min_key    = w_slot[1].vld ? FIELD_W'(w_slot[1].key) : '0;
                end
            end
        end
        n_rsp.occupancy  = OCC_W'(n_count);
        n_rsp.heap_empty = (n_count == '0);
    end

    // Count and response registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_rsp_vld <= w_accept;
            if (w_accept) begin
                r_rsp <= n_rsp;
            end
        end
    end

    assign o_rsp_vld = r_rsp_vld;
    assign o_rsp     = r_rsp;

    `BMHPQ_ASSERT_NOW(a_count, 1'b1, 32'(r_count) == $countones(w_vld) + $countones(w_cvld), "count disagrees with chain")
    `BMHPQ_ASSERT_NEXT(a_full_drop, w_accept && i_cmd.opcode == OP_PUSH && r_count == CNT_W'(CAPACITY), o_rsp.status == ST_FULL && $stable(r_count), "full push not dropped")
    `BMHPQ_ASSERT_NOW(a_empty_flag, o_rsp_vld, o_rsp.heap_empty == (o_rsp.occupancy == '0), "empty flag disagrees with occupancy")

endmodule

>>> design/bmhpq_cell.sv
// One cell of the sorted key chain: holds one key, passes the larger key to its right.
// Depends on bmhpq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "binary_min_heap_priority_queue_macros.svh"

module bmhpq_cell import bmhpq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_pop,
    input  t_slot i_carry,
    input  t_slot i_next,
    output t_slot o_slot,
    output t_slot o_carry
);

    t_slot r_slot, n_slot;
    t_slot r_carry, n_carry;

    // Insert or shift: keep the smaller key, hand the larger one on
    always_comb begin
        n_slot  = r_slot;
        n_carry = r_carry;
        n_carry.vld = 1'b0;
        if (i_pop) begin
            n_slot = i_next;
        end else if (i_carry.vld) begin
            if (!r_slot.vld) begin
                n_slot = i_carry;
            end else if (i_carry.key < r_slot.key) begin
                n_slot.key = i_carry.key;
                n_carry    = r_slot;
            end else begin
                n_carry = i_carry;
            end
        end
    end

    // Slot and carry registers; only valid bits reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.vld  <= 1'b0;
            r_carry.vld <= 1'b0;
        end else begin
            r_slot  <= n_slot;
            r_carry <= n_carry;
        end
    end

    assign o_slot  = r_slot;
    assign o_carry = r_carry;

    `BMHPQ_ASSERT_NOW(a_pop_no_carry, i_pop, !i_carry.vld, "pop while a key is in flight")
    `BMHPQ_ASSERT_NOW(a_sorted, r_slot.vld && i_next.vld && !i_pop, r_slot.key <= i_next.key, "chain out of order")
    `BMHPQ_ASSERT_NEXT(a_carry_lands, i_carry.vld && !r_slot.vld && !i_pop, !o_carry.vld && o_slot.vld, "carry passed an empty cell")

endmodule

>>> tb/sv/binary_min_heap_priority_queue_tb.sv
// Testbench for the binary min-heap priority queue: directed beats, then random push/pop traffic.
// Expected results come from an in-bench heap predictor. Depends on bmhpq_pkg and the
// binary_min_heap_priority_queue top.
`timescale 1ns / 1ps

module binary_min_heap_priority_queue_tb;
    import bmhpq_pkg::*;

    localparam int ITEM_TARGET  = 1450;
    localparam int MAX_REPORTS  = 10;
    localparam int SETTLE_CYCLES = CAPACITY + 8;

    // One directed beat, with a typed result where it is obvious
    typedef struct {
        t_cmd cmd;
        bit   known;
        t_rsp rsp;
    } t_step;

    // Planned beat as the monitor sees it at acceptance
    typedef struct {
        bit   known;
        t_rsp rsp;
    } t_plan;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_cmd i_cmd;
    logic busy;
    logic o_rsp_vld;
    t_rsp o_rsp;

    // Predictor state: array-ordered heap plus entry count
    logic [KEY_WIDTH-1:0] heap_keys [CAPACITY];
    int heap_size;

    t_step directed_steps[$];
    t_plan beat_plan_q[$];
    t_rsp  rsp_expect_q[$];

    int issued_count;
    int rsp_count;
    int mismatch_count;
    int stray_count;

    binary_min_heap_priority_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_rsp_vld(o_rsp_vld),
        .o_rsp    (o_rsp)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one command to the heap copy and return the result beat it yields
    function automatic t_rsp heap_apply(t_cmd c);
        t_rsp r;
        logic [KEY_WIDTH-1:0] tmp;
        int pos;
        int par;
        int lc;
        int pick;
        r = '0;
        r.status = ST_OK;
        if (c.opcode == OP_PUSH) begin
            if (heap_size >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                pos = heap_size;
                heap_keys[pos] = c.key_value[KEY_WIDTH-1:0];
                heap_size++;
                // sift up while strictly below the parent
                while (pos > 0) begin
                    par = (pos - 1) / 2;
                    if (heap_keys[pos] >= heap_keys[par]) break;
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[par];
                    heap_keys[par] = tmp;
                    pos = par;
                end
            end
        end else begin
            if (heap_size == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.popped_key = heap_keys[0];
                heap_size--;
                if (heap_size > 0) begin
                    heap_keys[0] = heap_keys[heap_size];
                    pos = 0;
                    // sift down toward the smaller child, left wins ties
                    forever begin
                        lc = 2 * pos + 1;
                        if (lc >= heap_size) break;
                        pick = lc;
                        if (lc + 1 < heap_size && heap_keys[lc + 1] < heap_keys[lc])
                            pick = lc + 1;
                        if (heap_keys[pos] <= heap_keys[pick]) break;
                        tmp = heap_keys[pos];
                        heap_keys[pos] = heap_keys[pick];
                        heap_keys[pick] = tmp;
                        pos = pick;
                    end
                end
            end
        end
        r.min_key    = (heap_size > 0) ? heap_keys[0] : '0;
        r.occupancy  = heap_size[OCC_W-1:0];
        r.heap_empty = (heap_size == 0);
        return r;
    endfunction

    // Monitor: check result beats, then record newly accepted commands
    always @(posedge i_clk) begin
        t_rsp  want;
        t_rsp  calc;
        t_plan plan;
        if (i_rst_n) begin
            if (o_rsp_vld) begin
                rsp_count++;
                if (rsp_expect_q.size() == 0) begin
                    stray_count++;
                    if (mismatch_count + stray_count <= MAX_REPORTS)
                        $display("unexpected result beat: popped=%h min=%h occ=%0d empty=%b st=%0d",
                                 o_rsp.popped_key, o_rsp.min_key, o_rsp.occupancy,
                                 o_rsp.heap_empty, o_rsp.status);
                end else begin
                    want = rsp_expect_q.pop_front();
                    if (o_rsp.popped_key !== want.popped_key ||
                        o_rsp.min_key    !== want.min_key    ||
                        o_rsp.occupancy  !== want.occupancy  ||
                        o_rsp.heap_empty !== want.heap_empty ||
                        o_rsp.status     !== want.status) begin
                        mismatch_count++;
                        if (mismatch_count + stray_count <= MAX_REPORTS)
                            $display("result %0d mismatch: exp popped=%h min=%h occ=%0d empty=%b st=%0d | got popped=%h min=%h occ=%0d empty=%b st=%0d",
                                     rsp_count, want.popped_key, want.min_key, want.occupancy,
                                     want.heap_empty, want.status, o_rsp.popped_key,
                                     o_rsp.min_key, o_rsp.occupancy, o_rsp.heap_empty,
                                     o_rsp.status);
                    end
                end
            end
            if (start && !busy) begin
                calc = heap_apply(i_cmd);
                if (beat_plan_q.size() != 0) begin
                    plan = beat_plan_q.pop_front();
                    if (plan.known) calc = plan.rsp;
                end
                rsp_expect_q.push_back(calc);
            end
        end
    end

    // Gap before the next beat: mostly none, sometimes short, rarely long
    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Key mix: full range, a narrow band for duplicates, and the corners
    function automatic logic [FIELD_W-1:0] draw_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return $urandom();
        if (roll < 85) return $urandom_range(0, 15);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    // Offer one command beat and hold it until the block takes it
    task automatic send_beat(input t_cmd c, input bit known, input t_rsp rsp);
        t_plan plan;
        plan.known = known;
        plan.rsp   = rsp;
        beat_plan_q.push_back(plan);
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        issued_count++;
    endtask

    // After a beat: either drain every result, idle a while, or go straight on
    task automatic after_beat(input bit drain, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : draw_gap();
        if (drain) begin
            start <= 1'b0;
            while (rsp_count < issued_count) @(posedge i_clk);
        end else if (gap > 0) begin
            start <= 1'b0;
            i_cmd <= {1'($urandom_range(0, 1)), 32'($urandom())};
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic add_step(input logic op, input logic [FIELD_W-1:0] key,
                            input bit known, input t_rsp rsp);
        t_step s;
        s.cmd.opcode    = op;
        s.cmd.key_value = key;
        s.known         = known;
        s.rsp           = rsp;
        directed_steps.push_back(s);
    endtask

    // Stimulus
    initial begin
        t_cmd c;
        int   seg_len;
        int   push_pct;
        int   seg_idx;
        bit   no_gaps;
        bit   drain;
        start          = 1'b0;
        i_cmd          = '0;
        i_rst_n        = 1'b0;
        heap_size      = 0;
        issued_count   = 0;
        rsp_count      = 0;
        mismatch_count = 0;
        stray_count    = 0;

        // Directed: underflow, corner keys, ties, then drain back to empty
        add_step(OP_POP,  32'h0,         1, t_rsp'{32'h0, 32'h0, 7'd0, 1'b1, ST_EMPTY});
        add_step(OP_POP,  32'hFFFF_FFFF, 1, t_rsp'{32'h0, 32'h0, 7'd0, 1'b1, ST_EMPTY});
        add_step(OP_PUSH, 32'hFFFF_FFFF, 1,
                 t_rsp'{32'h0, 32'hFFFF_FFFF, 7'd1, 1'b0, ST_OK});
        add_step(OP_POP,  32'h1234_5678, 1,
                 t_rsp'{32'hFFFF_FFFF, 32'h0, 7'd0, 1'b1, ST_OK});
        add_step(OP_PUSH, 32'h0,         1, t_rsp'{32'h0, 32'h0, 7'd1, 1'b0, ST_OK});
        add_step(OP_PUSH, 32'hFFFF_FFFF, 0, '0);
        add_step(OP_PUSH, 32'h8000_0000, 0, '0);
        add_step(OP_PUSH, 32'h7FFF_FFFF, 0, '0);
        add_step(OP_PUSH, 32'h0,         0, '0);
        add_step(OP_PUSH, 32'h1,         0, '0);
        add_step(OP_PUSH, 32'h1,         0, '0);
        add_step(OP_PUSH, 32'hAAAA_AAAA, 0, '0);
        add_step(OP_PUSH, 32'h5555_5555, 0, '0);
        for (int i = 0; i < 9; i++)
            add_step(OP_POP, (i % 2) ? 32'hFFFF_FFFF : 32'h0, 0, '0);
        add_step(OP_POP,  32'hFFFF_FFFF, 1, t_rsp'{32'h0, 32'h0, 7'd0, 1'b1, ST_EMPTY});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_steps[i]) begin
            send_beat(directed_steps[i].cmd, directed_steps[i].known, directed_steps[i].rsp);
            after_beat(i == directed_steps.size() - 1, 1'b0);
        end

        // Random segments: fill past full first, then drain past empty, then mixed
        seg_idx = 0;
        while (issued_count < ITEM_TARGET) begin
            case (seg_idx)
                0: begin push_pct = 85; seg_len = 130; end
                1: begin push_pct = 15; seg_len = 130; end
                default: begin
                    case ($urandom_range(0, 2))
                        0: push_pct = 85;
                        1: push_pct = 15;
                        default: push_pct = 50;
                    endcase
                    seg_len = $urandom_range(40, 160);
                end
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < seg_len && issued_count < ITEM_TARGET; n++) begin
                c.opcode    = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                c.key_value = draw_key();
                send_beat(c, 1'b0, '0);
                // hold off until every result is in at the end of some segments
                drain = (n == seg_len - 1) && (seg_idx == 0 || $urandom_range(0, 2) == 0);
                after_beat(drain, no_gaps);
            end
            seg_idx++;
        end

        // Wind down: all results in, then let any ripple settle
        start <= 1'b0;
        while (rsp_count < issued_count) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && stray_count == 0 && rsp_expect_q.size() == 0) begin
            $display("PASS binary_min_heap_priority_queue");
        end else begin
            $display("FAIL binary_min_heap_priority_queue");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #50_000_000;
        $display("FAIL binary_min_heap_priority_queue");
        $finish;
    end

endmodule

>>> binary_min_heap_priority_queue.f
+incdir+design
design/bmhpq_pkg.sv
design/bmhpq_cell.sv
design/binary_min_heap_priority_queue.sv
tb/sv/binary_min_heap_priority_queue_tb.sv
